FILE: rtl/crsp_pkg.sv
// package for the cache response stream parser
// field kind codes, protocol byte constants and result sideband layout
// no dependencies
`default_nettype none

package crsp_pkg;

    localparam int KIND_W  = 5;
    localparam int VALUE_W = 64;
    localparam int TUSER_W = 8;

    // m_tuser layout, lowest bit up
    localparam int TUSER_KIND_LO = 0;
    localparam int TUSER_SLAST   = 5;
    localparam int TUSER_OUTCOME = 6;
    localparam int TUSER_OVF     = 7;

    localparam logic [KIND_W-1:0] KIND_MAGIC      = 5'd0;
    localparam logic [KIND_W-1:0] KIND_MSG_ID     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_OPCODE     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_MARKER     = 5'd4;
    localparam logic [KIND_W-1:0] KIND_TOPO_ID    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_OWNERS     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_HASH_VER   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_HASH_SPACE = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SERVERS    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_VNODES     = 5'd10;
    localparam logic [KIND_W-1:0] KIND_HOST_BYTE  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_PORT       = 5'd12;
    localparam logic [KIND_W-1:0] KIND_HASH       = 5'd13;
    localparam logic [KIND_W-1:0] KIND_ERR_BYTE   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_VERSION    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_VAL_BYTE   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_KEY_BYTE   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_BVAL_BYTE  = 5'd18;

    localparam logic [7:0] OPC_GET           = 8'h04;
    localparam logic [7:0] OPC_GET_VERSIONED = 8'h12;
    localparam logic [7:0] OPC_BULK_GET      = 8'h1a;
    localparam logic [7:0] STATUS_OK         = 8'h00;
    localparam logic [7:0] STATUS_NOT_PUT    = 8'h01;
    localparam logic [7:0] STATUS_NOT_FOUND  = 8'h02;
    localparam logic [7:0] MARKER_TOPO       = 8'h01;
    localparam logic [7:0] BULK_END          = 8'h00;
    localparam logic [7:0] PROTO_VNODES      = 8'h0b;

    localparam logic [6:0] SHIFT_STEP = 7'd7;
    localparam logic [6:0] SHIFT_CAP  = 7'd70;

endpackage

`default_nettype wire

FILE: rtl/cache_response_stream_parser_core.sv
// cache response stream parser, top level
// byte register, parse state update and result register
// depends on crsp_pkg
`default_nettype none

// Takes one response byte per request on the s_ side and returns each completed field or
// payload byte on the m_ side. A byte can be taken in every cycle while the m_ side is not
// stalled: it is first held in an input register; when it advances, the parse state is
// updated from it and any result is loaded into the output register. Bytes that only
// advance a varint, a fixed field or a length emit nothing. The parse state update is the
// only feedback loop; a stalled m_ side holds the input register and, while that register
// is full, drops s_tready.
module cache_response_stream_parser_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [7:0]                  cfg_wr_data,    // protocol_version
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,        // rx_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [crsp_pkg::VALUE_W-1:0]     m_tdata,        // field_value
    output logic [crsp_pkg::TUSER_W-1:0]     m_tuser,        // field_kind[4:0], string_last,
                                                             // outcome, varint_overflow
    output logic                             m_tlast         // response_end
);
    import crsp_pkg::*;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_MSGID, PH_OPCODE, PH_STATUS, PH_MARKER, PH_TOPO_ID, PH_OWNERS,
        PH_HASHVER, PH_HASHSPACE, PH_SERVERS, PH_VNODES, PH_HOSTLEN, PH_HOSTBYTES,
        PH_PORT, PH_HASH, PH_ERRLEN, PH_ERRBYTES, PH_VERSION, PH_VALLEN, PH_VALBYTES,
        PH_BULKMARK, PH_KEYLEN, PH_KEYBYTES, PH_BVLEN, PH_BVBYTES
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   resp_end;
        logic   clr_varint;
        logic   clr_fixed;
    } act_t;

    function automatic act_t after_header(input logic [7:0] st, input logic [7:0] opc);
        act_t a;
        a = '{phase: PH_MAGIC, resp_end: 1'b1, clr_varint: 1'b0, clr_fixed: 1'b0};
        if (st != STATUS_OK) begin
            if (st != STATUS_NOT_PUT && st != STATUS_NOT_FOUND) begin
                a = '{phase: PH_ERRLEN, resp_end: 1'b0, clr_varint: 1'b1, clr_fixed: 1'b0};
            end
        end else begin
            case (opc)
                OPC_GET: begin
                    a = '{phase: PH_VALLEN, resp_end: 1'b0, clr_varint: 1'b1,
                          clr_fixed: 1'b0};
                end
                OPC_GET_VERSIONED: begin
                    a = '{phase: PH_VERSION, resp_end: 1'b0, clr_varint: 1'b0,
                          clr_fixed: 1'b1};
                end
                OPC_BULK_GET: begin
                    a = '{phase: PH_BULKMARK, resp_end: 1'b0, clr_varint: 1'b0,
                          clr_fixed: 1'b0};
                end
                default: ;
            endcase
        end
        return a;
    endfunction

    function automatic act_t begin_servers(input logic [31:0] srv, input logic [7:0] st,
                                           input logic [7:0] opc);
        act_t a;
        if (srv == 32'd0) begin
            a = after_header(st, opc);
        end else begin
            a = '{phase: PH_HOSTLEN, resp_end: 1'b0, clr_varint: 1'b1, clr_fixed: 1'b0};
        end
        return a;
    endfunction

    function automatic act_t finish_string(input phase_t ph);
        act_t a;
        case (ph)
            PH_HOSTBYTES: a = '{phase: PH_PORT, resp_end: 1'b0, clr_varint: 1'b0,
                                clr_fixed: 1'b1};
            PH_KEYBYTES:  a = '{phase: PH_BVLEN, resp_end: 1'b0, clr_varint: 1'b1,
                                clr_fixed: 1'b0};
            PH_BVBYTES:   a = '{phase: PH_BULKMARK, resp_end: 1'b0, clr_varint: 1'b0,
                                clr_fixed: 1'b0};
            default:      a = '{phase: PH_MAGIC, resp_end: 1'b1, clr_varint: 1'b0,
                                clr_fixed: 1'b0};
        endcase
        return a;
    endfunction

    function automatic logic [KIND_W-1:0] kind_of(input phase_t ph);
        logic [KIND_W-1:0] k;
        case (ph)
            PH_HOSTBYTES: k = KIND_HOST_BYTE;
            PH_ERRBYTES:  k = KIND_ERR_BYTE;
            PH_VALBYTES:  k = KIND_VAL_BYTE;
            PH_KEYBYTES:  k = KIND_KEY_BYTE;
            default:      k = KIND_BVAL_BYTE;
        endcase
        return k;
    endfunction

    // lengths and counts with the sign bit set count as zero
    function automatic logic [31:0] as_count(input logic [63:0] v);
        return v[31] ? 32'd0 : v[31:0];
    endfunction

    // control and state registers
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic [7:0]   pv_reg;
    phase_t       phase_reg, phase_next;
    logic [63:0]  acc_reg, acc_next;
    logic [6:0]   shift_reg, shift_next;
    logic [31:0]  rem_reg, rem_next;
    logic [63:0]  fword_reg, fword_next;
    logic [3:0]   fcount_reg, fcount_next;
    logic [31:0]  srv_reg, srv_next;
    logic [7:0]   opc_reg, opc_next;
    logic [7:0]   status_reg, status_next;
    logic         ovf_reg, ovf_next;

    // result register
    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_slast_reg;
    logic                m_end_reg;
    logic                m_outcome_reg;
    logic                m_ovf_reg;

    logic                advance;
    logic                s_accept;

    // varint and fixed field feed
    logic [70:0]  v_shifted;
    logic [63:0]  v_acc;
    logic         v_ovf;
    logic [6:0]   v_shift;
    logic         v_done;
    logic [63:0]  f_word;
    logic [3:0]   f_count;

    // per-byte decision
    act_t               act;
    logic               act_en;
    logic               emit;
    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic               r_slast;
    logic               r_end;
    logic               ovf_hit;
    logic               pend_now;
    logic [31:0]        len;
    logic [31:0]        rem_dec;
    logic [31:0]        srv_dec;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign v_shifted = 71'(in_byte_reg[6:0]) << shift_reg;
    assign v_done    = !in_byte_reg[7];
    assign v_shift   = (in_byte_reg[7] && shift_reg < SHIFT_CAP) ? shift_reg + SHIFT_STEP
                                                                 : shift_reg;
    assign f_word    = {fword_reg[55:0], in_byte_reg};
    assign f_count   = fcount_reg + 4'd1;
    assign len       = as_count(v_acc);
    assign rem_dec   = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;
    assign srv_dec   = (srv_reg != 32'd0) ? srv_reg - 32'd1 : srv_reg;

    always_comb begin
        if (phase_reg == PH_MSGID) begin
            if (shift_reg >= 7'd64) begin
                v_ovf = 1'b1;
                v_acc = acc_reg;
            end else begin
                v_ovf = |v_shifted[70:64];
                v_acc = acc_reg | v_shifted[63:0];
            end
        end else begin
            if (shift_reg >= 7'd32) begin
                v_ovf = 1'b1;
                v_acc = acc_reg;
            end else begin
                v_ovf = |v_shifted[63:32];
                v_acc = acc_reg | {32'd0, v_shifted[31:0]};
            end
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        fword_next  = fword_reg;
        fcount_next = fcount_reg;
        srv_next    = srv_reg;
        opc_next    = opc_reg;
        status_next = status_reg;
        act         = '{phase: PH_MAGIC, resp_end: 1'b0, clr_varint: 1'b0, clr_fixed: 1'b0};
        act_en      = 1'b0;
        emit        = 1'b0;
        r_kind      = KIND_MAGIC;
        r_value     = 64'd0;
        r_slast     = 1'b0;
        r_end       = 1'b0;
        ovf_hit     = 1'b0;

        unique case (phase_reg)
            PH_MAGIC: begin
                act    = '{phase: PH_MSGID, resp_end: 1'b0, clr_varint: 1'b1, clr_fixed: 1'b0};
                act_en = 1'b1;
                emit   = 1'b1;
                r_kind = KIND_MAGIC;
                r_value = 64'(in_byte_reg);
            end
            PH_OPCODE: begin
                opc_next   = in_byte_reg;
                phase_next = PH_STATUS;
                emit       = 1'b1;
                r_kind     = KIND_OPCODE;
                r_value    = 64'(in_byte_reg);
            end
            PH_STATUS: begin
                status_next = in_byte_reg;
                phase_next  = PH_MARKER;
                emit        = 1'b1;
                r_kind      = KIND_STATUS;
                r_value     = 64'(in_byte_reg);
            end
            PH_MARKER: begin
                if (in_byte_reg == MARKER_TOPO) begin
                    act = '{phase: PH_TOPO_ID, resp_end: 1'b0, clr_varint: 1'b1,
                            clr_fixed: 1'b0};
                end else begin
                    act = after_header(status_reg, opc_reg);
                end
                act_en  = 1'b1;
                emit    = 1'b1;
                r_kind  = KIND_MARKER;
                r_value = 64'(in_byte_reg);
                r_end   = act.resp_end;
            end
            PH_HASHVER: begin
                act     = '{phase: PH_HASHSPACE, resp_end: 1'b0, clr_varint: 1'b1,
                            clr_fixed: 1'b0};
                act_en  = 1'b1;
                emit    = 1'b1;
                r_kind  = KIND_HASH_VER;
                r_value = 64'(in_byte_reg);
            end
            PH_MSGID, PH_TOPO_ID, PH_HASHSPACE, PH_SERVERS, PH_VNODES, PH_HOSTLEN,
            PH_ERRLEN, PH_VALLEN, PH_KEYLEN, PH_BVLEN: begin
                acc_next   = v_acc;
                shift_next = v_shift;
                ovf_hit    = v_ovf;
                r_value    = v_acc;
                if (v_done) begin
                    act_en = 1'b1;
                    emit   = 1'b1;
                    case (phase_reg)
                        PH_MSGID: begin
                            act    = '{phase: PH_OPCODE, resp_end: 1'b0, clr_varint: 1'b0,
                                       clr_fixed: 1'b0};
                            r_kind = KIND_MSG_ID;
                        end
                        PH_TOPO_ID: begin
                            act    = '{phase: PH_OWNERS, resp_end: 1'b0, clr_varint: 1'b0,
                                       clr_fixed: 1'b1};
                            r_kind = KIND_TOPO_ID;
                        end
                        PH_HASHSPACE: begin
                            act    = '{phase: PH_SERVERS, resp_end: 1'b0, clr_varint: 1'b1,
                                       clr_fixed: 1'b0};
                            r_kind = KIND_HASH_SPACE;
                        end
                        PH_SERVERS: begin
                            srv_next = len;
                            if (pv_reg == PROTO_VNODES) begin
                                act = '{phase: PH_VNODES, resp_end: 1'b0, clr_varint: 1'b1,
                                        clr_fixed: 1'b0};
                            end else begin
                                act = begin_servers(len, status_reg, opc_reg);
                            end
                            r_kind = KIND_SERVERS;
                            r_end  = act.resp_end;
                        end
                        PH_VNODES: begin
                            act    = begin_servers(srv_reg, status_reg, opc_reg);
                            r_kind = KIND_VNODES;
                            r_end  = act.resp_end;
                        end
                        default: begin
                            // string length: the byte phase follows the length phase
                            r_kind  = kind_of(phase_t'(phase_reg + 5'd1));
                            r_value = 64'd0;
                            r_slast = 1'b1;
                            if (len == 32'd0) begin
                                act   = finish_string(phase_t'(phase_reg + 5'd1));
                                r_end = act.resp_end;
                            end else begin
                                emit     = 1'b0;
                                rem_next = len;
                                act      = '{phase: phase_t'(phase_reg + 5'd1),
                                             resp_end: 1'b0, clr_varint: 1'b0,
                                             clr_fixed: 1'b0};
                            end
                        end
                    endcase
                end
            end
            PH_OWNERS, PH_PORT, PH_HASH, PH_VERSION: begin
                fword_next  = f_word;
                fcount_next = f_count;
                act_en      = 1'b1;
                case (phase_reg)
                    PH_OWNERS: begin
                        r_kind  = KIND_OWNERS;
                        r_value = 64'(f_word[15:0]);
                        emit    = f_count >= 4'd2;
                        act     = '{phase: PH_HASHVER, resp_end: 1'b0, clr_varint: 1'b0,
                                    clr_fixed: 1'b0};
                    end
                    PH_PORT: begin
                        r_kind  = KIND_PORT;
                        r_value = 64'(f_word[15:0]);
                        emit    = f_count >= 4'd2;
                        act     = '{phase: PH_HASH, resp_end: 1'b0, clr_varint: 1'b0,
                                    clr_fixed: 1'b1};
                    end
                    PH_HASH: begin
                        r_kind  = KIND_HASH;
                        r_value = 64'(f_word[31:0]);
                        emit    = f_count >= 4'd4;
                        act     = begin_servers(srv_dec, status_reg, opc_reg);
                        if (emit) begin
                            srv_next = srv_dec;
                        end
                        r_end   = act.resp_end;
                    end
                    default: begin
                        r_kind  = KIND_VERSION;
                        r_value = f_word;
                        emit    = f_count >= 4'd8;
                        act     = '{phase: PH_VALLEN, resp_end: 1'b0, clr_varint: 1'b1,
                                    clr_fixed: 1'b0};
                    end
                endcase
                act_en = emit;
            end
            PH_BULKMARK: begin
                act_en = 1'b1;
                if (in_byte_reg == BULK_END) begin
                    act    = '{phase: PH_MAGIC, resp_end: 1'b1, clr_varint: 1'b0,
                               clr_fixed: 1'b0};
                    emit   = 1'b1;
                    r_kind = KIND_KEY_BYTE;
                    r_end  = 1'b1;
                end else begin
                    act = '{phase: PH_KEYLEN, resp_end: 1'b0, clr_varint: 1'b1,
                            clr_fixed: 1'b0};
                end
            end
            PH_HOSTBYTES, PH_ERRBYTES, PH_VALBYTES, PH_KEYBYTES, PH_BVBYTES: begin
                rem_next = rem_dec;
                emit     = 1'b1;
                r_kind   = kind_of(phase_reg);
                r_value  = 64'(in_byte_reg);
                r_slast  = rem_dec == 32'd0;
                act      = finish_string(phase_reg);
                act_en   = r_slast;
                r_end    = r_slast && act.resp_end;
            end
            default: begin
                phase_next = PH_MAGIC;
            end
        endcase

        if (act_en) begin
            phase_next = act.phase;
            if (act.clr_varint) begin
                acc_next   = 64'd0;
                shift_next = 7'd0;
            end
            if (act.clr_fixed) begin
                fword_next  = 64'd0;
                fcount_next = 4'd0;
            end
        end
    end

    assign pend_now = ovf_reg || ovf_hit;
    assign ovf_next = emit ? 1'b0 : pend_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pv_reg       <= PROTO_VNODES;
            phase_reg    <= PH_MAGIC;
            acc_reg      <= 64'd0;
            shift_reg    <= 7'd0;
            rem_reg      <= 32'd0;
            fword_reg    <= 64'd0;
            fcount_reg   <= 4'd0;
            srv_reg      <= 32'd0;
            opc_reg      <= 8'd0;
            status_reg   <= 8'd0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pv_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                shift_reg  <= shift_next;
                rem_reg    <= rem_next;
                fword_reg  <= fword_next;
                fcount_reg <= fcount_next;
                srv_reg    <= srv_next;
                opc_reg    <= opc_next;
                status_reg <= status_next;
                ovf_reg    <= ovf_next;
            end
            if (advance && emit) begin
                m_valid_reg   <= 1'b1;
                m_kind_reg    <= r_kind;
                m_value_reg   <= r_value;
                m_slast_reg   <= r_slast;
                m_end_reg     <= r_end;
                m_outcome_reg <= (r_kind >= KIND_STATUS) && (status_next != STATUS_OK);
                m_ovf_reg     <= pend_now;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_ovf_reg, m_outcome_reg, m_slast_reg, m_kind_reg};
    assign m_tlast  = m_end_reg;

endmodule

`default_nettype wire

FILE: rtl/crsp_checker.sv
// port-level checks for the cache response stream parser
// bound to cache_response_stream_parser_core, depends on crsp_pkg
`default_nettype none

module crsp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [crsp_pkg::VALUE_W-1:0]  m_tdata,
    input wire logic [crsp_pkg::TUSER_W-1:0]  m_tuser,
    input wire logic                          m_tlast
);
    import crsp_pkg::*;

    logic [KIND_W-1:0] kind;
    assign kind = m_tuser[TUSER_KIND_LO +: KIND_W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> kind <= KIND_BVAL_BYTE)
        else $error("field kind out of range");

    // outcome follows status, never reported before it
    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind < KIND_STATUS |-> !m_tuser[TUSER_OUTCOME])
        else $error("outcome set before status");

    // a response cannot end before the marker field
    a_end_early: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind < KIND_MARKER |-> !m_tlast)
        else $error("response end before marker");

    a_slast_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_SLAST] |->
            (kind == KIND_HOST_BYTE || kind == KIND_ERR_BYTE || kind == KIND_VAL_BYTE
             || kind == KIND_KEY_BYTE || kind == KIND_BVAL_BYTE))
        else $error("string end on non-string field");

endmodule

bind cache_response_stream_parser_core crsp_checker u_crsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
